// ----- design/irqmap_pkg.sv -----
// Shared types and constants for the interrupt range map table.
// Holds the request/response beat structs, table entry, status codes and states.
// No dependencies.
package irqmap_pkg;

   localparam int MAX_RANGES_DEF = 8;
   localparam logic [17:0] NUM_LIMIT = 18'd65536;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_ZERO     = 3'd2,
      STAT_OVERLAP  = 3'd3,
      STAT_NOTFOUND = 3'd4,
      STAT_TOOHIGH  = 3'd5
   } status_type;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_ADD    = 1'b1
   } opcode_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] irq_number;
      logic [7:0]  chip_id;
      logic [15:0] start_pos;
      logic        auto_place;
      logic [15:0] pin_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  found_chip;
      logic [15:0] local_pin;
      logic [3:0]  chips_used;
      logic [16:0] top_irq;
   } rsp_type;

   typedef struct packed {
      logic [15:0] first;
      logic [16:0] limit;
      logic [7:0]  chip;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_CHK,
      S_SCAN,
      S_CHECK,
      S_SHIFT,
      S_SHIFT_WR,
      S_INSERT
   } state_type;

endpackage

// ----- design/irq_range_map_table.sv -----
// Interrupt range map table: sorted ranges of global interrupt numbers per chip.
// Depends on irqmap_pkg for beat structs, entry layout, status codes and states.
//
// One beat is taken when start is high and busy is low; busy stays high until the
// result strobe. The table sits in a memory with one write port and a registered
// read port, and one compare unit walks it. A lookup steps through the entries in
// order and resolves on the first whose limit lies above the number, or reports not
// found after passing all entries in use. An add is first put through the full,
// zero-pin and range checks. Otherwise, when the range lies below the top number, it
// scans the entries for its place; it then moves the later entries up one by one and
// writes the new entry.
// rsp_valid is high for exactly one cycle per beat and cannot be stalled.
module irq_range_map_table
   import irqmap_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [16:0]      high_ff, high_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] spot_ff, spot_in;
   logic [16:0]      pos_ff, pos_in;
   logic [16:0]      end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   entry_type        mem [MAX_RANGES];
   entry_type        rd_q_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;

   logic [16:0]      cmp_key;
   logic             key_below;
   logic [17:0]      sum_wide;
   logic [16:0]      add_pos;
   logic [CNT_W-1:0] cur_dec;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
      spot_ff <= spot_in;
      pos_ff  <= pos_in;
      end_ff  <= end_in;
      rsp_ff  <= rsp_in;
   end

   assign cmp_key   = (req_ff.opcode == OP_LOOKUP) ? {1'b0, req_ff.irq_number} : pos_ff;
   assign key_below = (cmp_key < rd_q_ff.limit);
   assign add_pos   = req_ff.auto_place ? high_ff : {1'b0, req_ff.start_pos};
   assign sum_wide  = {1'b0, add_pos} + {2'b00, req_ff.pin_count};
   assign cur_dec   = cur_ff - CNT_ONE;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      used_in      = used_ff;
      high_in      = high_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      spot_in      = spot_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = idx_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = cur_ff[IDX_W-1:0];
      mem_wdata    = rd_q_ff;

      rsp_in.found_chip = '0;
      rsp_in.local_pin  = '0;
      rsp_in.chips_used = 4'(used_ff);
      rsp_in.top_irq    = high_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               idx_in   = '0;
               state_in = (req_data.opcode == OP_LOOKUP) ? S_SCAN : S_ADD_CHK;
            end
         end
         S_ADD_CHK: begin
            pos_in = add_pos;
            end_in = sum_wide[16:0];
            idx_in = '0;
            if (used_ff >= CNT_MAX) begin
               rsp_in.status = STAT_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (req_ff.pin_count == '0) begin
               rsp_in.status = STAT_ZERO;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (sum_wide > NUM_LIMIT) begin
               rsp_in.status = STAT_TOOHIGH;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (add_pos < high_ff) begin
               state_in = S_SCAN;
            end else begin
               spot_in  = used_ff;
               cur_in   = used_ff;
               state_in = S_SHIFT;
            end
         end
         S_SCAN: begin
            if (idx_ff >= used_ff) begin
               if (req_ff.opcode == OP_LOOKUP) begin
                  rsp_in.status = STAT_NOTFOUND;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  spot_in  = used_ff;
                  cur_in   = used_ff;
                  state_in = S_SHIFT;
               end
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!key_below) begin
               idx_in   = idx_ff + CNT_ONE;
               state_in = S_SCAN;
            end else if (req_ff.opcode == OP_LOOKUP) begin
               if (req_ff.irq_number >= rd_q_ff.first) begin
                  rsp_in.status     = STAT_OK;
                  rsp_in.found_chip = rd_q_ff.chip;
                  rsp_in.local_pin  = req_ff.irq_number - rd_q_ff.first;
               end else begin
                  rsp_in.status = STAT_NOTFOUND;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (end_ff > {1'b0, rd_q_ff.first}) begin
               rsp_in.status = STAT_OVERLAP;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               spot_in  = idx_ff;
               cur_in   = used_ff;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            rd_addr = cur_dec[IDX_W-1:0];
            if (cur_ff > spot_ff) begin
               state_in = S_SHIFT_WR;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff[IDX_W-1:0];
            mem_wdata = rd_q_ff;
            cur_in    = cur_dec;
            state_in  = S_SHIFT;
         end
         S_INSERT: begin
            mem_we          = 1'b1;
            mem_waddr       = spot_ff[IDX_W-1:0];
            mem_wdata.first = pos_ff[15:0];
            mem_wdata.limit = end_ff;
            mem_wdata.chip  = req_ff.chip_id;
            used_in         = used_ff + CNT_ONE;
            high_in         = (end_ff > high_ff) ? end_ff : high_ff;
            rsp_in.status     = STAT_OK;
            rsp_in.chips_used = 4'(used_in);
            rsp_in.top_irq    = high_in;
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for irq_range_map_table: directed and random lookup/add beats.
// Predicts each response from a local copy of the range table; uses irqmap_pkg types.
module testbench;
   import irqmap_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_BEATS = 440;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [15:0] range_first [MAX_RANGES_DEF];
   logic [16:0] range_limit [MAX_RANGES_DEF];
   logic [7:0]  range_owner [MAX_RANGES_DEF];
   int          range_count = 0;
   logic [16:0] top_number = '0;

   rsp_type pending_rsp[$];
   int      fail_count = 0;
   int      idle_cycles = 0;

   irq_range_map_table DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rsp_type map_predict(input req_type beat);
      rsp_type     r;
      logic [16:0] pos;
      logic [17:0] fin;
      int          spot;
      int          i;
      bit          hit;
      r = '0;
      hit = 1'b0;
      if (beat.opcode == OP_LOOKUP) begin
         r.status = STAT_NOTFOUND;
         for (i = 0; i < range_count; i++) begin
            if (!hit && {1'b0, beat.irq_number} < range_limit[i]) begin
               hit = 1'b1;
               if (beat.irq_number >= range_first[i]) begin
                  r.status = STAT_OK;
                  r.found_chip = range_owner[i];
                  r.local_pin = beat.irq_number - range_first[i];
               end
            end
         end
      end else if (range_count >= MAX_RANGES_DEF) begin
         r.status = STAT_FULL;
      end else if (beat.pin_count == 16'd0) begin
         r.status = STAT_ZERO;
      end else begin
         pos = beat.auto_place ? top_number : {1'b0, beat.start_pos};
         fin = pos + beat.pin_count;
         if (fin > NUM_LIMIT) begin
            r.status = STAT_TOOHIGH;
         end else begin
            spot = range_count;
            if (pos < top_number) begin
               for (i = 0; i < range_count; i++) begin
                  if (!hit && range_limit[i] > pos) begin
                     hit = 1'b1;
                     spot = i;
                  end
               end
            end
            if (spot < range_count && fin > range_first[spot]) begin
               r.status = STAT_OVERLAP;
            end else begin
               for (i = range_count; i > spot; i--) begin
                  range_first[i] = range_first[i - 1];
                  range_limit[i] = range_limit[i - 1];
                  range_owner[i] = range_owner[i - 1];
               end
               range_first[spot] = pos[15:0];
               range_limit[spot] = fin[16:0];
               range_owner[spot] = beat.chip_id;
               range_count++;
               if (fin > top_number) top_number = fin[16:0];
               r.status = STAT_OK;
            end
         end
      end
      r.chips_used = range_count[3:0];
      r.top_irq = top_number;
      return r;
   endfunction

   function automatic req_type random_beat(input opcode_type op);
      req_type b;
      b.opcode = op;
      b.irq_number = 16'($urandom_range(16'hFFFF));
      b.chip_id = 8'($urandom_range(8'hFF));
      b.start_pos = 16'($urandom_range(16'hFFFF));
      b.auto_place = 1'($urandom_range(1));
      b.pin_count = 16'($urandom_range(16'hFFFF));
      return b;
   endfunction

   function automatic req_type lookup_beat(input logic [15:0] irq);
      req_type b;
      b = random_beat(OP_LOOKUP);
      b.irq_number = irq;
      return b;
   endfunction

   function automatic req_type add_beat(input logic [7:0] chip, input logic [15:0] first,
                                        input logic autop, input logic [15:0] pins);
      req_type b;
      b = random_beat(OP_ADD);
      b.chip_id = chip;
      b.start_pos = first;
      b.auto_place = autop;
      b.pin_count = pins;
      return b;
   endfunction

   task automatic send_beat(input req_type beat);
      start <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(map_predict(beat));
   endtask

   task automatic sender_gap(input int pct);
      if (pct > 0 && $urandom_range(99) < pct) begin
         start <= 1'b0;
         req_data <= random_beat(opcode_type'($urandom_range(1)));
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   task automatic drain_rsp();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic test_empty_lookup();
      send_beat(lookup_beat(16'd0));
      send_beat(lookup_beat(16'hFFFF));
   endtask

   task automatic test_add_rejects();
      send_beat(add_beat(8'h12, 16'd100, 1'b0, 16'd0));
      send_beat(add_beat(8'h34, 16'hFFFF, 1'b0, 16'd2));
   endtask

   task automatic test_insert_order();
      send_beat(add_beat(8'hA5, 16'd1000, 1'b0, 16'd100));
      send_beat(add_beat(8'h5A, 16'd500, 1'b0, 16'd500));
      send_beat(add_beat(8'h77, 16'd999, 1'b0, 16'd2));
      send_beat(add_beat(8'h78, 16'd1099, 1'b0, 16'd1));
      send_beat(add_beat(8'hFF, 16'd0, 1'b0, 16'd1));
      send_beat(add_beat(8'h00, 16'hFFFF, 1'b1, 16'd16));
      send_beat(add_beat(8'h33, 16'd2000, 1'b0, 16'd10));
      send_beat(add_beat(8'h44, 16'd1500, 1'b0, 16'd500));
   endtask

   task automatic test_lookup_walk();
      send_beat(lookup_beat(16'd0));
      send_beat(lookup_beat(16'd1));
      send_beat(lookup_beat(16'd999));
      send_beat(lookup_beat(16'd1116));
      send_beat(lookup_beat(16'd2009));
      send_beat(lookup_beat(16'd2010));
      send_beat(lookup_beat(16'hFFFF));
   endtask

   task automatic test_top_limit();
      send_beat(add_beat(8'h99, 16'd0, 1'b1, 16'd63526));
      send_beat(lookup_beat(16'hFFFF));
      send_beat(add_beat(8'h9A, 16'd3000, 1'b1, 16'd1));
   endtask

   task automatic test_full_table();
      send_beat(add_beat(8'hC3, 16'd1200, 1'b0, 16'd100));
      send_beat(add_beat(8'hC4, 16'd1300, 1'b0, 16'd0));
      send_beat(add_beat(8'hC5, 16'd0, 1'b1, 16'hFFFF));
   endtask

   task automatic test_random_traffic();
      int          idle_pct [4] = '{0, 58, 0, 30};
      int          idx;
      logic [17:0] bound;
      req_type     beat;
      foreach (idle_pct[p]) begin
         if (p > 0) drain_rsp();
         for (int n = 0; n < PHASE_BEATS; n++) begin
            sender_gap(idle_pct[p]);
            if ($urandom_range(99) < 30) begin
               beat = random_beat(OP_ADD);
            end else if (range_count > 0 && $urandom_range(1)) begin
               idx = $urandom_range(range_count - 1);
               bound = $urandom_range(1) ? {2'b00, range_first[idx]} : {1'b0, range_limit[idx]};
               bound = bound + 18'($urandom_range(2)) - 18'd1;
               beat = lookup_beat(bound[15:0]);
            end else begin
               beat = random_beat(OP_LOOKUP);
            end
            send_beat(beat);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.found_chip !== want.found_chip) begin
               $error("found_chip: expected %0d, got %0d", want.found_chip,
                      rsp_data.found_chip);
               fail_count++;
            end
            if (rsp_data.local_pin !== want.local_pin) begin
               $error("local_pin: expected %0d, got %0d", want.local_pin, rsp_data.local_pin);
               fail_count++;
            end
            if (rsp_data.chips_used !== want.chips_used) begin
               $error("chips_used: expected %0d, got %0d", want.chips_used,
                      rsp_data.chips_used);
               fail_count++;
            end
            if (rsp_data.top_irq !== want.top_irq) begin
               $error("top_irq: expected %0d, got %0d", want.top_irq, rsp_data.top_irq);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_lookup();
      test_add_rejects();
      test_insert_order();
      test_lookup_walk();
      test_top_limit();
      test_full_table();
      test_random_traffic();
      drain_rsp();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- irq_range_map_table.f -----
design/irqmap_pkg.sv
design/irq_range_map_table.sv
tb/testbench.sv
